### hdl/msfc_pkg.sv
// ----------------------------------------------------------------------------
// msfc_pkg - shared definitions of the magic signature file classifier
// Signature table, category codes, counter widths and the view of the
// per-set state that the tracker hands to the signature matcher.
// ----------------------------------------------------------------------------
package msfc_pkg;

	localparam int TEXT_SCAN_LIMIT = 8192;
	localparam int HEAD_LEN        = 8;
	localparam int SEEN_W          = $clog2(TEXT_SCAN_LIMIT + 1);
	localparam int HEAD_IDX_W      = $clog2(HEAD_LEN);
	localparam int HEAD_W          = HEAD_LEN * 8;
	localparam int SIG_COUNT       = 27;
	localparam int CAT_W           = 4;
	localparam int IDX_W           = 5;
	localparam int LEN_W           = 4;

	localparam logic [IDX_W-1:0] NO_MATCH = IDX_W'(SIG_COUNT);

	localparam logic [CAT_W-1:0] CAT_UNKNOWN  = 4'd0;
	localparam logic [CAT_W-1:0] CAT_TEXT     = 4'd1;
	localparam logic [CAT_W-1:0] CAT_BINARY   = 4'd2;
	localparam logic [CAT_W-1:0] CAT_IMAGE    = 4'd3;
	localparam logic [CAT_W-1:0] CAT_AUDIO    = 4'd4;
	localparam logic [CAT_W-1:0] CAT_VIDEO    = 4'd5;
	localparam logic [CAT_W-1:0] CAT_ARCHIVE  = 4'd6;
	localparam logic [CAT_W-1:0] CAT_DOCUMENT = 4'd7;
	localparam logic [CAT_W-1:0] CAT_EXEC     = 4'd8;
	localparam logic [CAT_W-1:0] CAT_SCRIPT   = 4'd9;

	// Patterns hold the first byte in the top bits.
	localparam logic [LEN_W-1:0] SIG_LEN [SIG_COUNT] = '{
		4'd3, 4'd8, 4'd4, 4'd2, 4'd4, 4'd3, 4'd2, 4'd2, 4'd4,
		4'd4, 4'd4, 4'd3, 4'd4, 4'd4, 4'd4, 4'd6, 4'd6, 4'd2,
		4'd3, 4'd6, 4'd4, 4'd8, 4'd2, 4'd4, 4'd4, 4'd4, 4'd2
	};

	localparam logic [CAT_W-1:0] SIG_CAT [SIG_COUNT] = '{
		CAT_IMAGE, CAT_IMAGE, CAT_IMAGE, CAT_IMAGE, CAT_IMAGE,
		CAT_AUDIO, CAT_AUDIO, CAT_AUDIO, CAT_AUDIO, CAT_AUDIO, CAT_AUDIO,
		CAT_VIDEO, CAT_VIDEO,
		CAT_ARCHIVE, CAT_ARCHIVE, CAT_ARCHIVE, CAT_ARCHIVE, CAT_ARCHIVE,
		CAT_ARCHIVE, CAT_ARCHIVE,
		CAT_DOCUMENT, CAT_DOCUMENT,
		CAT_EXEC, CAT_EXEC, CAT_EXEC, CAT_EXEC,
		CAT_SCRIPT
	};

	localparam logic [HEAD_W-1:0] SIG_PAT [SIG_COUNT] = '{
		64'hFFD8FF00_00000000,
		64'h89504E47_0D0A1A0A,
		64'h47494638_00000000,
		64'h424D0000_00000000,
		64'h52494646_00000000,
		64'h49443300_00000000,
		64'hFFFB0000_00000000,
		64'hFFFA0000_00000000,
		64'h52494646_00000000,
		64'h4F676753_00000000,
		64'h664C6143_00000000,
		64'h00000000_00000000,
		64'h1A45DFA3_00000000,
		64'h504B0304_00000000,
		64'h504B0506_00000000,
		64'h52617221_1A070000,
		64'h377ABCAF_271C0000,
		64'h1F8B0000_00000000,
		64'h425A6800_00000000,
		64'hFD377A58_5A000000,
		64'h25504446_00000000,
		64'hD0CF11E0_A1B11AE1,
		64'h4D5A0000_00000000,
		64'h7F454C46_00000000,
		64'hCFFAEDFE_00000000,
		64'hCEFAEDFE_00000000,
		64'h23210000_00000000
	};

	// Head bytes packed with byte 0 in the top bits, as in the patterns.
	typedef struct packed {
		logic [HEAD_W-1:0] head;
		logic [SEEN_W-1:0] seen;
		logic              text;
	} msfc_view_t;

	function automatic logic is_non_text(input logic [7:0] c);
		logic r;
		r = (c < 8'h09) || ((c inside {[8'h0E:8'h1F]}) && (c != 8'h1B));
		return r;
	endfunction

endpackage

### hdl/msfc_track.sv
// ----------------------------------------------------------------------------
// msfc_track - per-set state tracker
// Holds the head bytes, the saturating byte count and the text flag, and
// presents the state as it stands once the current byte is taken in.
// ----------------------------------------------------------------------------
module msfc_track (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                commit,
	input  logic [7:0]          byte_value,
	input  logic                last,
	input  logic                empty_set,
	output msfc_pkg::msfc_view_t view
);

	logic [7:0]                  head_q [msfc_pkg::HEAD_LEN];
	logic [msfc_pkg::SEEN_W-1:0] bytes_seen_q;
	logic                        still_text_q;
	logic                        in_head;
	logic                        in_scan;
	logic                        end_set;

	assign in_head = bytes_seen_q < msfc_pkg::SEEN_W'(msfc_pkg::HEAD_LEN);
	assign in_scan = bytes_seen_q < msfc_pkg::SEEN_W'(msfc_pkg::TEXT_SCAN_LIMIT);
	assign end_set = last || empty_set;

	always_comb begin
		view.seen = in_scan ? bytes_seen_q + msfc_pkg::SEEN_W'(1) : bytes_seen_q;
		view.text = still_text_q && !(in_scan && msfc_pkg::is_non_text(byte_value));
		for (int i = 0; i < msfc_pkg::HEAD_LEN; i++) begin
			if (in_head && (bytes_seen_q[msfc_pkg::HEAD_IDX_W-1:0] == msfc_pkg::HEAD_IDX_W'(i)))
				view.head[msfc_pkg::HEAD_W-1-8*i -: 8] = byte_value;
			else
				view.head[msfc_pkg::HEAD_W-1-8*i -: 8] = head_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
			still_text_q <= 1'b1;
		end else if (commit) begin
			if (end_set) begin
				bytes_seen_q <= '0;
				still_text_q <= 1'b1;
			end else begin
				bytes_seen_q <= view.seen;
				still_text_q <= view.text;
			end
		end
	end

	// Head bytes are only read below the count, so they need no reset.
	always_ff @(posedge clk) begin
		if (commit && !empty_set && in_head)
			head_q[bytes_seen_q[msfc_pkg::HEAD_IDX_W-1:0]] <= byte_value;
	end

`ifndef SYNTH
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_seen_q <= msfc_pkg::SEEN_W'(msfc_pkg::TEXT_SCAN_LIMIT))
		else $error("byte count beyond scan limit");
	a_set_restart: assert property (@(posedge clk) disable iff (!arst_n)
		commit && end_set |=> bytes_seen_q == '0 && still_text_q)
		else $error("state not cleared after end of set");
	a_text_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		commit && !end_set && !still_text_q |=> !still_text_q)
		else $error("text flag set again within a set");
`endif

endmodule

### hdl/msfc_match.sv
// ----------------------------------------------------------------------------
// msfc_match - signature matcher
// Compares the head against every signature at once and picks the first
// hit in table order; with no hit it falls back to text or binary.
// ----------------------------------------------------------------------------
module msfc_match (
	input  msfc_pkg::msfc_view_t         view,
	output logic [msfc_pkg::CAT_W-1:0] category,
	output logic [msfc_pkg::IDX_W-1:0] signature_index
);

	logic [msfc_pkg::SIG_COUNT-1:0] hit;

	always_comb begin
		for (int k = 0; k < msfc_pkg::SIG_COUNT; k++) begin
			hit[k] = view.seen >= msfc_pkg::SEEN_W'(msfc_pkg::SIG_LEN[k]);
			for (int i = 0; i < msfc_pkg::HEAD_LEN; i++) begin
				if (msfc_pkg::LEN_W'(i) < msfc_pkg::SIG_LEN[k] &&
				    view.head[msfc_pkg::HEAD_W-1-8*i -: 8] !=
				    msfc_pkg::SIG_PAT[k][msfc_pkg::HEAD_W-1-8*i -: 8])
					hit[k] = 1'b0;
			end
		end
	end

	always_comb begin
		category        = view.text ? msfc_pkg::CAT_TEXT : msfc_pkg::CAT_BINARY;
		signature_index = msfc_pkg::NO_MATCH;
		for (int k = msfc_pkg::SIG_COUNT - 1; k >= 0; k--) begin
			if (hit[k]) begin
				category        = msfc_pkg::SIG_CAT[k];
				signature_index = msfc_pkg::IDX_W'(k);
			end
		end
	end

endmodule

### hdl/magic_signature_file_classifier.sv
// ----------------------------------------------------------------------------
// magic_signature_file_classifier - file type detection by magic signature
// Streams the bytes of a data set and classifies the set on its last byte.
// ----------------------------------------------------------------------------
// Usage: the input stream carries one byte of a data set per word in
// s_tdata, with s_tlast on the final byte. A word with s_tuser high stands
// for an empty set: its byte and tlast are ignored and it yields category
// unknown at once, dropping any partly received set. Every set yields exactly
// one result word on the output stream: category in bits 3:0 and signature
// index in bits 8:4 (27 when no signature matched). Words without tlast
// produce nothing on the output.
// Throughput is one word per cycle unless an end-of-set word waits for room
// in the output register. An accepted word sits in the input stage, where
// the tracker and the signature matcher work on it; the result enters the
// output register when the word leaves the input stage. The single input
// stage and the output register form the whole pipeline.
// Reset clears the pending words and the per-set count and text flag; the
// next word starts a new set. When the receiver stalls, the output register
// holds its word and one more end-of-set word waits in the input stage; after
// that s_tready drops. Words that produce no result keep flowing meanwhile.
// ----------------------------------------------------------------------------
module magic_signature_file_classifier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // byte_value
	input  logic        s_tlast,   // last
	input  logic        s_tuser,   // empty_set
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // category [3:0], signature_index [8:4], zero fill
);

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       empty_s1;

	// Output register.
	logic                         out_valid_q;
	logic [msfc_pkg::CAT_W-1:0]   out_cat_q;
	logic [msfc_pkg::IDX_W-1:0]   out_idx_q;

	logic                         s_acc;
	logic                         out_free;
	logic                         ends_s1;
	logic                         adv_s1;
	msfc_pkg::msfc_view_t         view;
	logic [msfc_pkg::CAT_W-1:0]   match_cat;
	logic [msfc_pkg::IDX_W-1:0]   match_idx;

	// A word that ends a set needs room in the output register; any other
	// word leaves the input stage unconditionally.
	assign out_free = !out_valid_q || m_tready;
	assign ends_s1  = last_s1 || empty_s1;
	assign adv_s1   = valid_s1 && (!ends_s1 || out_free);
	assign s_tready = !valid_s1 || adv_s1;
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_acc)
			valid_s1 <= 1'b1;
		else if (adv_s1)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			byte_s1  <= s_tdata;
			last_s1  <= s_tlast;
			empty_s1 <= s_tuser;
		end
	end

	msfc_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.commit     (adv_s1),
		.byte_value (byte_s1),
		.last       (last_s1),
		.empty_set  (empty_s1),
		.view       (view)
	);

	msfc_match u_match (
		.view            (view),
		.category        (match_cat),
		.signature_index (match_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv_s1 && ends_s1)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && ends_s1) begin
			out_cat_q <= empty_s1 ? msfc_pkg::CAT_UNKNOWN : match_cat;
			out_idx_q <= empty_s1 ? msfc_pkg::NO_MATCH : match_idx;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_idx_q, out_cat_q};

`ifndef SYNTH
	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ends_s1 && out_free |=> m_tvalid)
		else $error("end of set did not produce a result");
	a_unknown_no_sig: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_cat_q == msfc_pkg::CAT_UNKNOWN |-> out_idx_q == msfc_pkg::NO_MATCH)
		else $error("unknown category with a signature index");
	a_sig_category: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_idx_q != msfc_pkg::NO_MATCH |->
		out_cat_q != msfc_pkg::CAT_UNKNOWN && out_cat_q != msfc_pkg::CAT_TEXT &&
		out_cat_q != msfc_pkg::CAT_BINARY)
		else $error("matched signature with a fallback category");
	a_fallback_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (out_cat_q == msfc_pkg::CAT_TEXT || out_cat_q == msfc_pkg::CAT_BINARY) |->
		out_idx_q == msfc_pkg::NO_MATCH)
		else $error("fallback category with a signature index");
`endif

endmodule
